FILE: hw/rtl/aws_pkg.sv
// ----------------------------------------------------------------------------
// aws_pkg
// shared types, codes and the waypoint table of the axis waypoint sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package aws_pkg;

	// field widths
	localparam int TPOS_W     = 24;
	localparam int VEL_W      = 20;
	localparam int ACC_W      = 28;
	localparam int FAC_W      = 8;
	localparam int WPC_W      = 4;
	localparam int CNT_W      = 3;
	localparam int CODE_W     = 4;
	localparam int MODE_W     = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 28;
	localparam int TBL_IDX_W  = 6;

	// parameter defaults
	localparam int DEF_MAX_WAYPOINTS = 8;
	localparam int DEF_POSITION_BITS = 24;

	// request codes on the mode field
	localparam logic [MODE_W-1:0] MODE_NONE  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_HOME  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_START = 2'd2;
	localparam logic [MODE_W-1:0] MODE_STOP  = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WP_COUNT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACC_FACTOR = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HOME_POS   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_HOME_VEL   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HOME_ACC   = 3'd4;

	// reported state codes
	localparam logic [CODE_W-1:0] SC_ACTIVE = 4'd0;
	localparam logic [CODE_W-1:0] SC_POWER  = 4'd1;
	localparam logic [CODE_W-1:0] SC_HOME   = 4'd2;
	localparam logic [CODE_W-1:0] SC_WAIT   = 4'd3;
	localparam logic [CODE_W-1:0] SC_LOAD   = 4'd4;
	localparam logic [CODE_W-1:0] SC_MOVE1  = 4'd5;
	localparam logic [CODE_W-1:0] SC_MOVE2  = 4'd6;
	localparam logic [CODE_W-1:0] SC_HLOAD  = 4'd7;
	localparam logic [CODE_W-1:0] SC_HMOVE1 = 4'd8;
	localparam logic [CODE_W-1:0] SC_HMOVE2 = 4'd9;
	localparam logic [CODE_W-1:0] SC_STOP   = 4'd10;
	localparam logic [CODE_W-1:0] SC_ERROR  = 4'd11;

	typedef enum logic [11:0] {
		ST_ACTIVE = 12'b0000_0000_0001,
		ST_POWER  = 12'b0000_0000_0010,
		ST_HOME   = 12'b0000_0000_0100,
		ST_WAIT   = 12'b0000_0000_1000,
		ST_LOAD   = 12'b0000_0001_0000,
		ST_MOVE1  = 12'b0000_0010_0000,
		ST_MOVE2  = 12'b0000_0100_0000,
		ST_HLOAD  = 12'b0000_1000_0000,
		ST_HMOVE1 = 12'b0001_0000_0000,
		ST_HMOVE2 = 12'b0010_0000_0000,
		ST_STOP   = 12'b0100_0000_0000,
		ST_ERROR  = 12'b1000_0000_0000
	} state_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              axis_active;
		logic              axis_powered;
		logic              axis_homed;
		logic              axis_error;
		logic              param_ack;
		logic              axis_move_active;
		logic              in_position_done;
		logic              peer_move_active;
		logic              peer_start;
		logic              peer_stop;
	} item_t;

	typedef struct packed {
		logic [CODE_W-1:0]        seq_state;
		logic [CNT_W-1:0]         waypoint_index;
		logic signed [TPOS_W-1:0] target_position;
		logic [VEL_W-1:0]         target_velocity;
		logic [ACC_W-1:0]         target_accel;
		logic                     update_cmd;
		logic                     move_cmd;
		logic                     home_cmd;
	} res_t;

	typedef struct packed {
		logic [WPC_W-1:0]         waypoint_count;
		logic [FAC_W-1:0]         accel_factor;
		logic signed [TPOS_W-1:0] home_position;
		logic [VEL_W-1:0]         home_velocity;
		logic [ACC_W-1:0]         home_accel;
	} cfg_t;

	function automatic logic [CODE_W-1:0] state_code(input state_t st);
		logic [CODE_W-1:0] c;
		case (st)
			ST_ACTIVE: c = SC_ACTIVE;
			ST_POWER:  c = SC_POWER;
			ST_HOME:   c = SC_HOME;
			ST_WAIT:   c = SC_WAIT;
			ST_LOAD:   c = SC_LOAD;
			ST_MOVE1:  c = SC_MOVE1;
			ST_MOVE2:  c = SC_MOVE2;
			ST_HLOAD:  c = SC_HLOAD;
			ST_HMOVE1: c = SC_HMOVE1;
			ST_HMOVE2: c = SC_HMOVE2;
			ST_STOP:   c = SC_STOP;
			default:   c = SC_ERROR;
		endcase
		return c;
	endfunction

	// waypoint positions, hundredths of a unit
	function automatic logic [31:0] wp_position(input logic [TBL_IDX_W-1:0] idx);
		logic [31:0] v;
		case (idx)
			6'd0:    v = 32'd70000;
			6'd1:    v = 32'd30000;
			6'd2:    v = 32'd60000;
			6'd3:    v = 32'd20000;
			6'd4:    v = 32'd75000;
			6'd5:    v = 32'd40000;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

	// waypoint velocities, hundredths per second
	function automatic logic [VEL_W-1:0] wp_velocity(input logic [TBL_IDX_W-1:0] idx);
		logic [VEL_W-1:0] v;
		case (idx)
			6'd0:    v = 20'd30000;
			6'd1:    v = 20'd28000;
			6'd2:    v = 20'd13000;
			6'd3:    v = 20'd20000;
			6'd4:    v = 20'd13000;
			6'd5:    v = 20'd29000;
			default: v = 20'd0;
		endcase
		return v;
	endfunction

endpackage

FILE: hw/rtl/aws_if.sv
// ----------------------------------------------------------------------------
// aws channel interfaces
// status item, result item and configuration write channels
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface aws_item_if;
	logic           valid;
	logic           ready;
	aws_pkg::item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface aws_res_if;
	logic          valid;
	logic          ready;
	aws_pkg::res_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface aws_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [aws_pkg::CFG_IDX_W-1:0]  index;
	logic [aws_pkg::CFG_DATA_W-1:0] wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

FILE: hw/rtl/aws_seq.sv
// ----------------------------------------------------------------------------
// aws_seq
// sequencer state, command latches, held targets and the waypoint table port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aws_seq #(
	parameter int MAX_WAYPOINTS = aws_pkg::DEF_MAX_WAYPOINTS,
	parameter int POSITION_BITS = aws_pkg::DEF_POSITION_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  aws_pkg::item_t item,
	input  aws_pkg::cfg_t  cfg,
	output aws_pkg::res_t  res
);
	import aws_pkg::*;

	localparam int AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
	localparam logic [TPOS_W-1:0] POS_KEEP = (POSITION_BITS >= TPOS_W) ? {TPOS_W{1'b1}} :
		TPOS_W'((64'd1 << POSITION_BITS) - 64'd1);

	state_t st_q, st_n;
	logic [CNT_W-1:0] cnt_q, cnt_n, cnt_rd;
	logic home_req_q, start_req_q, stop_req_q;
	logic home_req_n, start_req_n, stop_req_n;
	logic upd_q, mv_q, hl_q, upd_n, mv_n, hl_n;
	logic [TPOS_W-1:0] pos_q, pos_n;
	logic [VEL_W-1:0] vel_q, vel_n;
	logic [ACC_W-1:0] acc_q, acc_n;

	// registered table read port, always holds the entry at the counter
	logic [AW-1:0] rd_addr;
	logic [TPOS_W-1:0] tbl_pos_q;
	logic [VEL_W-1:0] tbl_vel_q;
	logic [ACC_W-1:0] tbl_acc;

	logic [WPC_W-1:0] eff_cnt;
	logic [WPC_W-1:0] cnt_inc;

	always_comb begin
		if (cfg.waypoint_count == '0) begin
			eff_cnt = WPC_W'(1);
		end else if (32'(cfg.waypoint_count) > MAX_WAYPOINTS) begin
			eff_cnt = WPC_W'(MAX_WAYPOINTS);
		end else begin
			eff_cnt = cfg.waypoint_count;
		end
	end

	assign cnt_inc = {1'b0, cnt_q} + WPC_W'(1);
	assign tbl_acc = {{(ACC_W-VEL_W){1'b0}}, tbl_vel_q} * {{(ACC_W-FAC_W){1'b0}}, cfg.accel_factor};

	always_comb begin
		home_req_n  = home_req_q  | (item.mode == MODE_HOME);
		start_req_n = start_req_q | (item.mode == MODE_START);
		stop_req_n  = stop_req_q  | (item.mode == MODE_STOP);
		st_n  = st_q;
		cnt_n = cnt_q;
		upd_n = upd_q;
		mv_n  = mv_q;
		hl_n  = hl_q;
		pos_n = pos_q;
		vel_n = vel_q;
		acc_n = acc_q;
		case (st_q)
			ST_ACTIVE: begin
				if (item.axis_active) st_n = ST_POWER;
			end
			ST_POWER: begin
				if (item.axis_powered) st_n = ST_HOME;
			end
			ST_HOME: begin
				if (item.axis_homed) begin
					hl_n = 1'b0;
					home_req_n = 1'b0;
					st_n = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (home_req_n) st_n = ST_HLOAD;
				// start wins over home
				if (start_req_n || item.peer_start) begin
					cnt_n = '0;
					st_n = ST_LOAD;
				end
			end
			ST_LOAD: begin
				pos_n = tbl_pos_q;
				vel_n = tbl_vel_q;
				acc_n = tbl_acc;
				upd_n = 1'b1;
				if (item.param_ack) st_n = ST_MOVE1;
			end
			ST_MOVE1: begin
				if (item.peer_move_active) begin
					mv_n = 1'b1;
					if (item.axis_move_active) st_n = ST_MOVE2;
				end
			end
			ST_MOVE2: begin
				if (stop_req_n || item.peer_stop) begin
					st_n = ST_STOP;
				end else if (item.in_position_done) begin
					mv_n = 1'b0;
					if (cnt_inc >= eff_cnt) begin
						st_n = ST_WAIT;
					end else begin
						cnt_n = cnt_q + CNT_W'(1);
						st_n = ST_LOAD;
					end
				end
			end
			ST_HLOAD: begin
				pos_n = cfg.home_position & POS_KEEP;
				vel_n = cfg.home_velocity;
				acc_n = cfg.home_accel;
				upd_n = 1'b1;
				if (item.param_ack) st_n = ST_HMOVE1;
			end
			ST_HMOVE1: begin
				mv_n = 1'b1;
				if (item.axis_move_active) st_n = ST_HMOVE2;
			end
			ST_HMOVE2: begin
				if (item.in_position_done) begin
					mv_n = 1'b0;
					home_req_n = 1'b0;
					st_n = ST_WAIT;
				end
			end
			ST_STOP: begin
				stop_req_n = 1'b0;
				start_req_n = 1'b0;
				mv_n = 1'b0;
				if (!item.axis_move_active) st_n = ST_WAIT;
			end
			default: begin
				home_req_n = 1'b0;
				upd_n = 1'b0;
				stop_req_n = 1'b0;
				start_req_n = 1'b0;
				mv_n = 1'b0;
				st_n = item.axis_error ? ST_ERROR : ST_WAIT;
			end
		endcase
		if (home_req_n && !item.axis_homed) hl_n = 1'b1;
		if (item.axis_error) st_n = ST_ERROR;
	end

	// read ahead at the counter value that the next cycle will hold
	assign cnt_rd = accept ? cnt_n : cnt_q;
	assign rd_addr = (32'(cnt_rd) >= MAX_WAYPOINTS) ? '0 : AW'(cnt_rd);

	always_ff @(posedge clk) begin
		tbl_pos_q <= POS_KEEP & TPOS_W'(wp_position(TBL_IDX_W'(rd_addr)));
		tbl_vel_q <= wp_velocity(TBL_IDX_W'(rd_addr));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_ACTIVE;
			cnt_q <= '0;
			home_req_q <= 1'b0;
			start_req_q <= 1'b0;
			stop_req_q <= 1'b0;
			upd_q <= 1'b0;
			mv_q <= 1'b0;
			hl_q <= 1'b0;
			pos_q <= '0;
			vel_q <= '0;
			acc_q <= '0;
		end else if (accept) begin
			st_q <= st_n;
			cnt_q <= cnt_n;
			home_req_q <= home_req_n;
			start_req_q <= start_req_n;
			stop_req_q <= stop_req_n;
			upd_q <= upd_n;
			mv_q <= mv_n;
			hl_q <= hl_n;
			pos_q <= pos_n;
			vel_q <= vel_n;
			acc_q <= acc_n;
		end
	end

	always_comb begin
		res.seq_state = state_code(st_n);
		res.waypoint_index = cnt_n;
		res.target_position = pos_n;
		res.target_velocity = vel_n;
		res.target_accel = acc_n;
		res.update_cmd = upd_n;
		res.move_cmd = mv_n;
		res.home_cmd = hl_n;
	end

	a_err_forces: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.axis_error) |=> (st_q == ST_ERROR))
		else $error("axis error did not force the error state");

	a_load_sets_update: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && st_q == ST_LOAD) |=> upd_q)
		else $error("update request not raised after a waypoint load");

	a_homed_to_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && st_q == ST_HOME && item.axis_homed && !item.axis_error)
		|=> (st_q == ST_WAIT && !home_req_q))
		else $error("homed axis did not reach wait with home request cleared");

endmodule

FILE: hw/rtl/axis_waypoint_sequencer.sv
// ----------------------------------------------------------------------------
// axis_waypoint_sequencer
// One status transaction per control tick steps the sequencer and yields one
// result transaction showing the state after that tick. Items are taken at one
// per clock while the skid entry is free: the per-tick transition is a single
// registered step, and the waypoint table is read through a registered port
// addressed ahead with the counter value the next tick will see, so a load never
// waits on the table. The result of an item appears in the output register
// on the cycle after its acceptance when that register is free or being
// taken, otherwise it waits in the skid entry; this two-entry output buffer
// (output register plus skid) keeps input ready high while one result waits,
// and ready drops only when both entries are full. Configuration transactions
// are always taken and should only be issued while no result is outstanding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module axis_waypoint_sequencer #(
	parameter int MAX_WAYPOINTS = aws_pkg::DEF_MAX_WAYPOINTS,
	parameter int POSITION_BITS = aws_pkg::DEF_POSITION_BITS
) (
	input logic       clk,
	input logic       arst_n,
	aws_item_if.sink  item,
	aws_res_if.source result,
	aws_cfg_if.sink   cfg
);
	import aws_pkg::*;

	cfg_t cfg_q;
	res_t res_next;
	res_t out_q, skid_q;
	logic out_vld_q, skid_vld_q;
	logic acc_in, take;

	// configuration registers, writes beyond the list are dropped
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.waypoint_count <= WPC_W'(6);
			cfg_q.accel_factor <= FAC_W'(10);
			cfg_q.home_position <= TPOS_W'(40000);
			cfg_q.home_velocity <= VEL_W'(10000);
			cfg_q.home_accel <= ACC_W'(100000);
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				CFG_WP_COUNT:   cfg_q.waypoint_count <= cfg.wdata[WPC_W-1:0];
				CFG_ACC_FACTOR: cfg_q.accel_factor <= cfg.wdata[FAC_W-1:0];
				CFG_HOME_POS:   cfg_q.home_position <= cfg.wdata[TPOS_W-1:0];
				CFG_HOME_VEL:   cfg_q.home_velocity <= cfg.wdata[VEL_W-1:0];
				CFG_HOME_ACC:   cfg_q.home_accel <= cfg.wdata[ACC_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake: accept while the skid entry is free
	assign item.ready = !skid_vld_q;
	assign acc_in = item.valid && item.ready;
	assign take = result.valid && result.ready;

	// sequencer core, steps once per accepted transaction
	aws_seq #(
		.MAX_WAYPOINTS(MAX_WAYPOINTS),
		.POSITION_BITS(POSITION_BITS)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.accept(acc_in),
		.item(item.data),
		.cfg(cfg_q),
		.res(res_next)
	);

	// output buffer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (take) begin
			if (skid_vld_q) begin
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= acc_in;
			end
		end else if (acc_in) begin
			if (out_vld_q) begin
				skid_vld_q <= 1'b1;
			end else begin
				out_vld_q <= 1'b1;
			end
		end
	end

	// output buffer payload
	always_ff @(posedge clk) begin
		if (take) begin
			if (skid_vld_q) begin
				out_q <= skid_q;
			end else if (acc_in) begin
				out_q <= res_next;
			end
		end else if (acc_in) begin
			if (out_vld_q) begin
				skid_q <= res_next;
			end else begin
				out_q <= res_next;
			end
		end
	end

	assign result.valid = out_vld_q;
	assign result.data = out_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid entry filled while output register is empty");

	a_stall_fills_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_in && out_vld_q && !take) |=> skid_vld_q)
		else $error("transaction accepted under stall was not buffered");

	a_accept_shows: assert property (@(posedge clk) disable iff (!arst_n)
		acc_in |=> out_vld_q)
		else $error("accepted transaction produced no result");

endmodule
